@@ hdl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property check, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked implication check, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication check, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/u2d_pkg.sv @@
// constants for the binary to decimal ascii converter
package u2d_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned CHAR_W      = 6;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned MAX_DIGITS  = 10;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned PROD_W      = 2 * VALUE_W;
  localparam int unsigned RECIP_SHIFT = 35;
  localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;

  // ceil(2^35 / 10), exact floor division by ten for any 32-bit value
  localparam logic [VALUE_W-1:0] RECIP_TEN  = 32'hCCCC_CCCD;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
  localparam logic [CNT_W-1:0]   LAST_IDX   = 4'd9;

endpackage

@@ hdl/u2d_div10.sv @@
// shared divide-by-ten unit: registered reciprocal multiply, remainder from low bits
module u2d_div10 (
  input  logic                           clk_i,
  input  logic [u2d_pkg::VALUE_W-1:0]    dividend_i,
  output logic [u2d_pkg::QUOT_W-1:0]     quot_o,
  output logic [u2d_pkg::DIGIT_W-1:0]    rem_o
);

  logic [u2d_pkg::PROD_W-1:0]  prod;
  logic [u2d_pkg::VALUE_W-1:0] dividend_q;
  logic [u2d_pkg::QUOT_W-1:0]  quot_q;
  logic [u2d_pkg::DIGIT_W-1:0] q_times_ten;

  assign prod = {{u2d_pkg::VALUE_W{1'b0}}, dividend_i}
              * {{u2d_pkg::VALUE_W{1'b0}}, u2d_pkg::RECIP_TEN};

  always_ff @(posedge clk_i) begin
    dividend_q <= dividend_i;
    quot_q     <= prod[u2d_pkg::PROD_W-1:u2d_pkg::RECIP_SHIFT];
  end

  // remainder is below ten, so only the low four bits of q*10 matter
  assign q_times_ten = {quot_q[0], 3'b000} + {quot_q[2:0], 1'b0};
  assign rem_o       = dividend_q[u2d_pkg::DIGIT_W-1:0] - q_times_ten;
  assign quot_o      = quot_q;

endmodule

@@ hdl/u32_to_decimal_ascii.sv @@
// top level: 32-bit unsigned value to a run of decimal ascii digits
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+---------------------------
//  command  | in        | start high while busy is low | value_i
//  result   | out       | result_valid_o per digit     | digit_char_o, last_o
//
// one item holds n digits (1..10): each digit passes through the
// shared divide-by-ten unit (multiply, then remainder), then the digits go out.
// digits leave most significant first, one per cycle, with no gaps within a run.
// busy stays high while the item is divided and emitted, and drops in the cycle that carries the last digit.
// reset clears the sequencer and the result strobe; the receiver cannot stall.
`include "assert_macros.svh"

module u32_to_decimal_ascii (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [u2d_pkg::VALUE_W-1:0]  value_i,
  output logic                         result_valid_o,
  output logic [u2d_pkg::CHAR_W-1:0]   digit_char_o,
  output logic                         last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_EMIT
  } state_e;

  state_e                        state_q;
  logic [u2d_pkg::VALUE_W-1:0]   val_q;
  logic [u2d_pkg::CNT_W-1:0]     cnt_q;
  logic [u2d_pkg::DIGIT_W-1:0]   dig_q [u2d_pkg::MAX_DIGITS];
  logic                          valid_q;
  logic [u2d_pkg::CHAR_W-1:0]    char_q;
  logic                          last_q;

  logic [u2d_pkg::QUOT_W-1:0]    quot;
  logic [u2d_pkg::DIGIT_W-1:0]   rem;

  u2d_div10 u_div10 (
    .clk_i      (clk_i),
    .dividend_i (val_q),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  assign busy = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            val_q   <= value_i;
            cnt_q   <= '0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          // quotient is being registered inside the divide unit
          state_q <= ST_SUB;
        end
        ST_SUB: begin
          dig_q[cnt_q] <= rem;
          val_q        <= {{(u2d_pkg::VALUE_W - u2d_pkg::QUOT_W){1'b0}}, quot};
          if (quot == '0 || cnt_q == u2d_pkg::LAST_IDX) begin
            state_q <= ST_EMIT;
          end else begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= ST_MUL;
          end
        end
        ST_EMIT: begin
          // walk back down the stored digits, most significant first
          valid_q <= 1'b1;
          char_q  <= u2d_pkg::ASCII_ZERO
                   + {{(u2d_pkg::CHAR_W - u2d_pkg::DIGIT_W){1'b0}}, dig_q[cnt_q]};
          last_q  <= (cnt_q == '0);
          if (cnt_q == '0) begin
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o = valid_q;
  assign digit_char_o   = char_q;
  assign last_o         = last_q;

  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "busy not raised after accept")
  `ASSERT_NEXT(a_run_contiguous, clk_i, rst_ni, result_valid_o && !last_o, result_valid_o, "gap inside a digit run")
  `ASSERT_NEXT(a_run_ends, clk_i, rst_ni, result_valid_o && last_o, !result_valid_o, "output after last digit")
  `ASSERT_IMPL(a_digit_range, clk_i, rst_ni, result_valid_o, digit_char_o >= 6'd48 && digit_char_o <= 6'd57, "digit out of range")

endmodule

@@ tb/sv/tb_top.sv @@
// testbench for the 32-bit binary to decimal ascii converter
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned RADIX     = 10;
  localparam int          SHOW_MAX  = 10;
  localparam int          DIRECTED_N = 25;
  localparam int          RANDOM_N  = 155;
  localparam int          DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [u2d_pkg::CHAR_W-1:0] ch;
    logic                       fin;
  } digit_item_t;

  // keeps the digit runs still owed by the block, oldest first
  class digit_run_tracker;
    digit_item_t pending_chars[$];
    int          faults;
    int          shown;

    function new();
      faults = 0;
      shown  = 0;
    endfunction

    // work out the decimal run of an accepted value
    function void note_value(logic [u2d_pkg::VALUE_W-1:0] v);
      logic [u2d_pkg::VALUE_W-1:0] rest;
      logic [u2d_pkg::VALUE_W-1:0] r10;
      digit_item_t                 run[$];
      digit_item_t                 d;
      bit                          first;
      rest  = v;
      first = 1'b1;
      do begin
        r10   = rest % RADIX;
        d.ch  = u2d_pkg::ASCII_ZERO + r10[u2d_pkg::CHAR_W-1:0];
        d.fin = first;
        run.push_front(d);
        first = 1'b0;
        rest  = rest / RADIX;
      end while (rest != 0);
      foreach (run[i]) pending_chars.push_back(run[i]);
    endfunction

    function void report(string msg);
      faults++;
      if (shown < SHOW_MAX) begin
        shown++;
        $display("%0t mismatch: %s", $realtime, msg);
      end
    endfunction

    function void check_char(logic [u2d_pkg::CHAR_W-1:0] ch, logic fin);
      digit_item_t want;
      if (pending_chars.size() == 0) begin
        report($sformatf("unexpected digit char %0d last %0b", ch, fin));
        return;
      end
      want = pending_chars.pop_front();
      if (ch !== want.ch)
        report($sformatf("digit char expected %0d got %0d", want.ch, ch));
      if (fin !== want.fin)
        report($sformatf("last expected %0b got %0b", want.fin, fin));
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic [u2d_pkg::VALUE_W-1:0] value_i;
  logic                        result_valid_o;
  logic [u2d_pkg::CHAR_W-1:0]  digit_char_o;
  logic                        last_o;

  digit_run_tracker board = new();

  u32_to_decimal_ascii uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .value_i        (value_i),
    .result_valid_o (result_valid_o),
    .digit_char_o   (digit_char_o),
    .last_o         (last_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // accepts and results both sampled on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) board.note_value(value_i);
      if (result_valid_o) board.check_char(digit_char_o, last_o);
    end
  end

  // values spread over every digit count, with some fully random ones
  function automatic logic [u2d_pkg::VALUE_W-1:0] pick_value();
    int                n;
    longint unsigned   p;
    longint unsigned   lo;
    longint unsigned   hi;
    longint unsigned   r;
    longint unsigned   s;
    if ($urandom_range(4) == 0) return $urandom;
    n = $urandom_range(1, u2d_pkg::MAX_DIGITS);
    p = 1;
    repeat (n - 1) p = p * RADIX;
    lo = (n == 1) ? 0 : p;
    hi = p * RADIX - 1;
    if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
    r = {$urandom, $urandom};
    s = lo + r % (hi - lo + 1);
    return s[u2d_pkg::VALUE_W-1:0];
  endfunction

  // offer the item each cycle, idling about one cycle in three when allowed,
  // until it is taken
  task automatic send_value(logic [u2d_pkg::VALUE_W-1:0] v, bit may_idle);
    bit taken;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      if (may_idle && $urandom_range(2) == 0) begin
        start   <= 1'b0;
        value_i <= $urandom;
      end else begin
        start   <= 1'b1;
        value_i <= v;
      end
      @(posedge clk_i);
      taken = start && !busy;
    end
  endtask

  logic [u2d_pkg::VALUE_W-1:0] directed_vals [DIRECTED_N] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd999, 32'd1000,
    32'd9999, 32'd10000, 32'd99999, 32'd100000, 32'd999999, 32'd1000000,
    32'd9999999, 32'd10000000, 32'd99999999, 32'd100000000, 32'd999999999,
    32'd1000000000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA
  };

  initial begin
    rst_ni  = 1'b0;
    start   = 1'b0;
    value_i = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_vals[i]) send_value(directed_vals[i], 1'b1);
    // a stretch without idling in the middle of the random part
    for (int i = 0; i < RANDOM_N; i++) send_value(pick_value(), (i < 60 || i >= 110));
    @(negedge clk_i);
    start <= 1'b0;

    while (board.pending_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.faults == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/u2d_pkg.sv
hdl/u2d_div10.sv
hdl/u32_to_decimal_ascii.sv
tb/sv/tb_top.sv
